// ===== rtl/rtpc_pkg.sv =====
// Shared types and constants for the right triangle polar converter.
// Used by rtpc_cordic_stage and right_triangle_polar_convert_core; no dependencies.
package rtpc_pkg;

  localparam int unsigned SIDE_BITS_DEF  = 16;
  localparam int unsigned ITERATIONS_DEF = 18;

  localparam int unsigned IN_FIELD_W   = 16;
  localparam int unsigned HYP_W        = 25;
  localparam int unsigned ANG_W        = 23;
  localparam int unsigned GUARD_BITS   = 24;
  localparam int unsigned OUT_FRAC     = 8;
  localparam int unsigned ANG_ACC_W    = 32;
  localparam int unsigned MAX_STAGES   = 32;

  // Limiting inverse CORDIC gain, Q30
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  // 90 degrees with 16 fraction bits
  localparam logic [ANG_W-1:0] RIGHT_ANGLE = 23'd5898240;

  // round(atan(2^-i) * 180/pi * 2^24)
  localparam logic [ANG_ACC_W-1:0] ATAN_DEG_Q24 [MAX_STAGES] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115,
    32'd57,        32'd29,        32'd14,        32'd7,
    32'd4,         32'd2,         32'd1,         32'd0
  };

  // Control that travels alongside the datapath
  typedef struct packed {
    logic valid;
    logic degen;   // both legs zero
    logic a_zero;  // only leg a zero
    logic b_zero;  // only leg b zero
  } ctl_t;

endpackage

// ===== rtl/rtpc_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation with its side-band control.
// Depends on rtpc_pkg (ctl_t, atan table).
module rtpc_cordic_stage #(
  parameter int unsigned XW    = 43,
  parameter int unsigned SB    = 16,
  parameter int unsigned SHIFT = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rtpc_pkg::ctl_t                     ctl_i,
  input  logic signed [XW-1:0]               x_i,
  input  logic signed [XW-1:0]               y_i,
  input  logic signed [rtpc_pkg::ANG_ACC_W-1:0] z_i,
  input  logic [SB-1:0]                      leg_i,
  output rtpc_pkg::ctl_t                     ctl_o,
  output logic signed [XW-1:0]               x_o,
  output logic signed [XW-1:0]               y_o,
  output logic signed [rtpc_pkg::ANG_ACC_W-1:0] z_o,
  output logic [SB-1:0]                      leg_o
);
  import rtpc_pkg::*;

  localparam logic signed [ANG_ACC_W-1:0] ATAN_C = $signed(ATAN_DEG_Q24[SHIFT]);

  ctl_t                         ctl_r;
  logic signed [XW-1:0]         x_r, y_r, x_nxt, y_nxt;
  logic signed [ANG_ACC_W-1:0]  z_r, z_nxt;
  logic [SB-1:0]                leg_r;

  always_comb begin
    logic signed [XW-1:0] xs, ys;
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    if (!y_i[XW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN_C;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    leg_r <= leg_i;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign leg_o = leg_r;

endmodule

// ===== rtl/right_triangle_polar_convert_core.sv =====
// Rectangular-to-polar converter for right triangle legs: unrolled CORDIC pipeline.
// Depends on rtpc_pkg and rtpc_cordic_stage.
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+----------------------
//  request | in_side_a, in_side_b                               | start && !busy
//  result  | out_hypotenuse, out_angle_opposite_a/_b,           | out_valid, one cycle
//          | out_degenerate                                     |
//
// One request per cycle while busy is low; the result is registered through an input
// register, one register per micro-rotation, and the gain-multiply and sum stages.
// The gain multiply is split into partial products of two 32-bit halves, summed a stage later.
// Synchronous active-low reset clears the control flags (valid, degen, a_zero, b_zero) only;
// busy is set during reset and cleared once it is released. Results cannot be held off by the receiver.
module right_triangle_polar_convert_core #(
  parameter int unsigned SIDE_BITS  = rtpc_pkg::SIDE_BITS_DEF,
  parameter int unsigned ITERATIONS = rtpc_pkg::ITERATIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [rtpc_pkg::IN_FIELD_W-1:0]    in_side_a,
  input  logic [rtpc_pkg::IN_FIELD_W-1:0]    in_side_b,
  output logic                               out_valid,
  output logic [rtpc_pkg::HYP_W-1:0]         out_hypotenuse,
  output logic [rtpc_pkg::ANG_W-1:0]         out_angle_opposite_a,
  output logic [rtpc_pkg::ANG_W-1:0]         out_angle_opposite_b,
  output logic                               out_degenerate
);
  import rtpc_pkg::*;

  localparam int unsigned XW    = SIDE_BITS + GUARD_BITS + 3;
  localparam int unsigned IN_W  = (SIDE_BITS < IN_FIELD_W) ? SIDE_BITS : IN_FIELD_W;
  localparam int unsigned LAT   = ITERATIONS + 3;

  // ---------------- input stage ----------------
  logic                 busy_r;
  logic                 accept;
  logic [SIDE_BITS-1:0] a_in, b_in;
  ctl_t                 ctl_nxt;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign a_in   = SIDE_BITS'(in_side_a[IN_W-1:0]);
  assign b_in   = SIDE_BITS'(in_side_b[IN_W-1:0]);

  always_comb begin
    ctl_nxt.valid  = accept;
    ctl_nxt.degen  = (a_in == '0) && (b_in == '0);
    ctl_nxt.b_zero = (a_in != '0) && (b_in == '0);
    ctl_nxt.a_zero = (a_in == '0) && (b_in != '0);
  end

  ctl_t                          ctl_p [ITERATIONS+1];
  logic signed [XW-1:0]          x_p   [ITERATIONS+1];
  logic signed [XW-1:0]          y_p   [ITERATIONS+1];
  logic signed [ANG_ACC_W-1:0]   z_p   [ITERATIONS+1];
  logic [SIDE_BITS-1:0]          leg_p [ITERATIONS+1];

  ctl_t                          ctl0_r;
  logic signed [XW-1:0]          x0_r, y0_r;
  logic [SIDE_BITS-1:0]          leg0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      ctl0_r <= '0;
    end else begin
      busy_r <= 1'b0;
      ctl0_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r   <= $signed(XW'({b_in, {GUARD_BITS{1'b0}}}));
    y0_r   <= $signed(XW'({a_in, {GUARD_BITS{1'b0}}}));
    leg0_r <= (b_in == '0) ? a_in : b_in;
  end

  assign ctl_p[0] = ctl0_r;
  assign x_p[0]   = x0_r;
  assign y_p[0]   = y0_r;
  assign z_p[0]   = '0;
  assign leg_p[0] = leg0_r;

  // ---------------- micro-rotations ----------------
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
    rtpc_cordic_stage #(
      .XW    (XW),
      .SB    (SIDE_BITS),
      .SHIFT (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_p[i]),
      .x_i   (x_p[i]),
      .y_i   (y_p[i]),
      .z_i   (z_p[i]),
      .leg_i (leg_p[i]),
      .ctl_o (ctl_p[i+1]),
      .x_o   (x_p[i+1]),
      .y_o   (y_p[i+1]),
      .z_o   (z_p[i+1]),
      .leg_o (leg_p[i+1])
    );
  end

  // ---------------- gain partial products, angle rounding ----------------
  ctl_t                  ctl1_r;
  logic [61:0]           lo_r, hi_r, lo_nxt, hi_nxt;
  logic [ANG_W-1:0]      ang1_r, ang1_nxt;
  logic [SIDE_BITS-1:0]  leg1_r;

  always_comb begin
    logic [63:0]        x_pos;
    logic signed [32:0] z_rnd;
    logic signed [32:0] z_sh;
    x_pos  = (x_p[ITERATIONS] > 0) ? 64'($unsigned(x_p[ITERATIONS])) : 64'd0;
    lo_nxt = 62'(x_pos[31:0])  * 62'(INV_GAIN_Q30);
    hi_nxt = 62'(x_pos[63:32]) * 62'(INV_GAIN_Q30);
    z_rnd  = 33'(z_p[ITERATIONS]) + 33'sd128;
    z_sh   = z_rnd >>> 8;
    if (z_sh < 0) begin
      ang1_nxt = '0;
    end else if (z_sh > $signed(33'(RIGHT_ANGLE))) begin
      ang1_nxt = RIGHT_ANGLE;
    end else begin
      ang1_nxt = z_sh[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl_p[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    ang1_r <= ang1_nxt;
    leg1_r <= leg_p[ITERATIONS];
  end

  // ---------------- sum, special cases, output register ----------------
  logic                  valid_r;
  logic [HYP_W-1:0]      hyp_r, hyp_nxt;
  logic [ANG_W-1:0]      anga_r, anga_nxt, angb_r, angb_nxt;
  logic                  degen_r;

  always_comb begin
    logic [62:0]              lo_rnd;
    logic [62:0]              sum;
    logic [SIDE_BITS+32:0]    leg_sc;
    lo_rnd = 63'(lo_r) + (63'd1 << 45);
    sum    = 63'(hi_r) + (lo_rnd >> 32);
    leg_sc = (SIDE_BITS+33)'(leg1_r) << OUT_FRAC;
    if (ctl1_r.degen) begin
      hyp_nxt  = '0;
      anga_nxt = '0;
      angb_nxt = '0;
    end else if (ctl1_r.b_zero) begin
      hyp_nxt  = leg_sc[HYP_W-1:0];
      anga_nxt = RIGHT_ANGLE;
      angb_nxt = '0;
    end else if (ctl1_r.a_zero) begin
      hyp_nxt  = leg_sc[HYP_W-1:0];
      anga_nxt = '0;
      angb_nxt = RIGHT_ANGLE;
    end else begin
      hyp_nxt  = sum[HYP_W+13:14];
      anga_nxt = ang1_r;
      angb_nxt = RIGHT_ANGLE - ang1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    hyp_r   <= hyp_nxt;
    anga_r  <= anga_nxt;
    angb_r  <= angb_nxt;
    degen_r <= ctl1_r.degen;
  end

  assign out_valid            = valid_r;
  assign out_hypotenuse       = hyp_r;
  assign out_angle_opposite_a = anga_r;
  assign out_angle_opposite_b = angb_r;
  assign out_degenerate       = degen_r;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted request did not produce a result on time");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_hypotenuse == '0 && out_angle_opposite_a == '0 && out_angle_opposite_b == '0))
    else $error("degenerate result carries nonzero fields");

  a_angle_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate) |->
      ((24'(out_angle_opposite_a) + 24'(out_angle_opposite_b)) == 24'(RIGHT_ANGLE)))
    else $error("angles do not sum to 90 degrees");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_opposite_a <= RIGHT_ANGLE))
    else $error("angle out of range");

endmodule

// ===== tb/sv/rtpc_polar_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for right_triangle_polar_convert_core: predicts each CORDIC result.
// Watches the request and result ports and compares them field by field.
// Depends on rtpc_pkg for port widths only.
module rtpc_polar_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [rtpc_pkg::IN_FIELD_W-1:0] in_side_a,
  input  logic [rtpc_pkg::IN_FIELD_W-1:0] in_side_b,
  input  logic                            out_valid,
  input  logic [rtpc_pkg::HYP_W-1:0]      out_hypotenuse,
  input  logic [rtpc_pkg::ANG_W-1:0]      out_angle_opposite_a,
  input  logic [rtpc_pkg::ANG_W-1:0]      out_angle_opposite_b,
  input  logic                            out_degenerate,
  output int unsigned                     fail_count,
  output int unsigned                     pending,
  output int unsigned                     checked_count,
  output int unsigned                     axis_count
);
  import rtpc_pkg::IN_FIELD_W;
  import rtpc_pkg::HYP_W;
  import rtpc_pkg::ANG_W;

  localparam int unsigned STAGES       = 18;
  localparam int unsigned MAX_PRINTS   = 60;
  localparam longint      RIGHT_Q16    = 64'sd5898240;   // 90 deg, 16 frac bits
  localparam logic [127:0] GAIN_Q30    = 128'd652032874; // limiting 1/K

  typedef struct packed {
    logic [IN_FIELD_W-1:0] leg_a;
    logic [IN_FIELD_W-1:0] leg_b;
    logic [HYP_W-1:0]      hyp;
    logic [ANG_W-1:0]      ang_a;
    logic [ANG_W-1:0]      ang_b;
    logic                  degen;
  } polar_result_t;

  polar_result_t expected_polar_q[$];
  int unsigned   printed;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic longint atan_step_q24(input int unsigned i);
    case (i)
      0: return 754974720;   1: return 445687602;  2: return 235489088;  3: return 119537938;
      4: return 60000934;    5: return 30029717;   6: return 15018523;   7: return 7509720;
      8: return 3754917;     9: return 1877466;   10: return 938734;    11: return 469367;
      12: return 234684;    13: return 117342;    14: return 58671;     15: return 29335;
      16: return 14668;     17: return 7334;      18: return 3667;      19: return 1833;
      20: return 917;       21: return 458;       22: return 229;       23: return 115;
      24: return 57;        25: return 29;        26: return 14;        27: return 7;
      28: return 4;         29: return 2;         30: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic polar_result_t predict_polar(input logic [IN_FIELD_W-1:0] a,
                                                  input logic [IN_FIELD_W-1:0] b);
    polar_result_t r;
    longint        x, y, z, xs, ys, ang;
    logic [127:0]  prod;
    r = '0;
    r.leg_a = a;
    r.leg_b = b;
    ang = 0;
    if (a == 0 && b == 0) begin
      r.degen = 1'b1;
    end else if (b == 0) begin
      r.hyp = HYP_W'({a, 8'h00});
      ang = RIGHT_Q16;
    end else if (a == 0) begin
      r.hyp = HYP_W'({b, 8'h00});
    end else begin
      x = longint'(b) <<< 24;
      y = longint'(a) <<< 24;
      z = 0;
      for (int unsigned i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step_q24(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step_q24(i);
        end
      end
      ang = (z + 128) >>> 8;
      if (ang < 0) ang = 0;
      if (ang > RIGHT_Q16) ang = RIGHT_Q16;
      if (x > 0) begin
        prod = 128'(x) * GAIN_Q30 + (128'd1 << 45);
        r.hyp = prod[46 +: HYP_W];
      end
    end
    r.ang_a = ANG_W'(ang);
    r.ang_b = r.degen ? '0 : ANG_W'(RIGHT_Q16 - ang);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (printed < MAX_PRINTS) begin
      printed++;
      $display("[%0t] MISMATCH %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    polar_result_t e;
    if (!rst_n) begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
      axis_count    = 0;
      printed       = 0;
      expected_polar_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_polar_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          e = expected_polar_q.pop_front();
          checked_count++;
          if (out_hypotenuse !== e.hyp)
            report_mismatch($sformatf("hypotenuse a=%0d b=%0d got %0d exp %0d",
                                      e.leg_a, e.leg_b, out_hypotenuse, e.hyp));
          if (out_angle_opposite_a !== e.ang_a)
            report_mismatch($sformatf("angle_a a=%0d b=%0d got %0d exp %0d",
                                      e.leg_a, e.leg_b, out_angle_opposite_a, e.ang_a));
          if (out_angle_opposite_b !== e.ang_b)
            report_mismatch($sformatf("angle_b a=%0d b=%0d got %0d exp %0d",
                                      e.leg_a, e.leg_b, out_angle_opposite_b, e.ang_b));
          if (out_degenerate !== e.degen)
            report_mismatch($sformatf("degenerate a=%0d b=%0d got %0b exp %0b",
                                      e.leg_a, e.leg_b, out_degenerate, e.degen));
        end
      end
      if (start && !busy) begin
        expected_polar_q.push_back(predict_polar(in_side_a, in_side_b));
        if (in_side_a == 0 || in_side_b == 0) axis_count++;
      end
      pending = expected_polar_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the right_triangle_polar_convert_core testbench: clock, reset, request stimulus.
// Instantiates the core and rtpc_polar_checker; depends on rtpc_pkg.
module tb_top;
  import rtpc_pkg::IN_FIELD_W;
  import rtpc_pkg::HYP_W;
  import rtpc_pkg::ANG_W;

  localparam int unsigned RANDOM_REQS   = 1750;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 30;   // pipeline is ITERATIONS+3 deep
  localparam int unsigned IDLE_PCT      = 22;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [IN_FIELD_W-1:0] in_side_a = '0;
  logic [IN_FIELD_W-1:0] in_side_b = '0;
  logic                  out_valid;
  logic [HYP_W-1:0]      out_hypotenuse;
  logic [ANG_W-1:0]      out_angle_opposite_a;
  logic [ANG_W-1:0]      out_angle_opposite_b;
  logic                  out_degenerate;

  int unsigned fail_count, pending, checked_count, axis_count;
  int unsigned req_count = 0;
  int unsigned stall_cycles = 0;

  always #5 clk = ~clk;

  right_triangle_polar_convert_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_side_a(in_side_a), .in_side_b(in_side_b),
    .out_valid(out_valid), .out_hypotenuse(out_hypotenuse),
    .out_angle_opposite_a(out_angle_opposite_a),
    .out_angle_opposite_b(out_angle_opposite_b),
    .out_degenerate(out_degenerate)
  );

  rtpc_polar_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_side_a(in_side_a), .in_side_b(in_side_b),
    .out_valid(out_valid), .out_hypotenuse(out_hypotenuse),
    .out_angle_opposite_a(out_angle_opposite_a),
    .out_angle_opposite_b(out_angle_opposite_b),
    .out_degenerate(out_degenerate),
    .fail_count(fail_count), .pending(pending),
    .checked_count(checked_count), .axis_count(axis_count)
  );

  // watchdog: no request and no result for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Drives one request, with random idle cycles ahead of it when allowed.
  task automatic send_legs(input logic [IN_FIELD_W-1:0] a, input logic [IN_FIELD_W-1:0] b,
                           input bit may_idle);
    while (may_idle && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_side_a <= a;
    in_side_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    req_count++;
  endtask

  function automatic logic [IN_FIELD_W-1:0] rand_leg(input int unsigned lo,
                                                     input int unsigned hi);
    return IN_FIELD_W'($urandom_range(hi, lo));
  endfunction

  initial begin
    int unsigned sel;
    logic [IN_FIELD_W-1:0] a, b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // corners: both zero, one leg zero, extremes, classic triples, bit patterns
    send_legs(16'd0, 16'd0, 1'b0);
    send_legs(16'd1, 16'd0, 1'b0);
    send_legs(16'hFFFF, 16'd0, 1'b1);
    send_legs(16'd0, 16'd1, 1'b1);
    send_legs(16'd0, 16'hFFFF, 1'b1);
    send_legs(16'd1, 16'd1, 1'b1);
    send_legs(16'hFFFF, 16'hFFFF, 1'b1);
    send_legs(16'hFFFF, 16'd1, 1'b1);
    send_legs(16'd1, 16'hFFFF, 1'b1);
    send_legs(16'd3, 16'd4, 1'b1);
    send_legs(16'd5, 16'd12, 1'b1);
    send_legs(16'h8000, 16'h8000, 1'b1);
    send_legs(16'h5555, 16'hAAAA, 1'b1);
    send_legs(16'hAAAA, 16'h5555, 1'b1);
    send_legs(16'h7FFF, 16'h8000, 1'b1);
    send_legs(16'd0, 16'd0, 1'b1);
    send_legs(16'hFFFF, 16'hFFFE, 1'b1);
    send_legs(16'd2, 16'd1, 1'b1);
    send_legs(16'd1, 16'd2, 1'b1);
    send_legs(16'h8000, 16'd0, 1'b1);

    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        // one leg on an axis (sometimes both)
        a = $urandom_range(9) == 0 ? '0 : IN_FIELD_W'($urandom);
        b = '0;
        if ($urandom_range(1)) begin
          b = a;
          a = '0;
        end
      end else if (sel < 22) begin
        a = rand_leg(1, 255);
        b = rand_leg(1, 255);
      end else if (sel < 36) begin
        a = IN_FIELD_W'($urandom);
        b = a + rand_leg(0, 7) - 16'd3;
      end else if (sel < 46) begin
        a = rand_leg(1, 15);
        b = rand_leg(16'hF000, 16'hFFFF);
        if ($urandom_range(1)) {a, b} = {b, a};
      end else begin
        a = IN_FIELD_W'($urandom);
        b = IN_FIELD_W'($urandom);
      end
      // a long back-to-back stretch in the middle
      send_legs(a, b, !(n >= 500 && n < 900));
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending != 0) $display("%0d results never arrived", pending);
    $display("Covered %0d requests (%0d with a leg on an axis), %0d results compared.",
             req_count, axis_count, checked_count);
    $display("Legs spanned zero, one, near-equal, extreme-ratio and full-range values.");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
